[hw/rtl/per_class_box_suppression_assert.svh]
// assertion macros for the per-class box suppression rtl
`ifndef PER_CLASS_BOX_SUPPRESSION_ASSERT_SVH
`define PER_CLASS_BOX_SUPPRESSION_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PCBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PCBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/pcbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_pkg
// types, state codes and helpers for the per-class box suppression block
// ----------------------------------------------------------------------------
package pcbs_pkg;

  localparam int unsigned CoordW = 14;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ClassW = 4;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned DataW  = 80;
  localparam logic [ThrW-1:0] ThrReset = 16'd29491;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [ScoreW-1:0] score;
    logic [CoordW-1:0] y2;
    logic [CoordW-1:0] x2;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x1;
  } box_t;

  localparam int unsigned BoxW = $bits(box_t);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_SUP_I,
    ST_SUP_A,
    ST_SUP_AB,
    ST_SUP_AAREA,
    ST_PJ,
    ST_PB,
    ST_PC,
    ST_PI,
    ST_PAREA,
    ST_PU,
    ST_PT,
    ST_PCMP,
    ST_FLUSH
  } state_e;

  // signed extent hi - lo of one axis
  function automatic logic signed [CoordW:0] extent(logic [CoordW-1:0] lo,
                                                     logic [CoordW-1:0] hi);
    extent = $signed({1'b0, hi}) - $signed({1'b0, lo});
  endfunction

  // overlap length of two spans, clamped at zero
  function automatic logic [CoordW-1:0] overlap(logic [CoordW-1:0] alo, logic [CoordW-1:0] ahi,
                                                logic [CoordW-1:0] blo, logic [CoordW-1:0] bhi);
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    logic signed [CoordW:0] d;
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    d  = extent(lo, hi);
    overlap = (d > 0) ? d[CoordW-1:0] : '0;
  endfunction

endpackage

[hw/rtl/pcbs_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_store
// box memories: one write port, box read on port a, score read on port b
// ----------------------------------------------------------------------------
module pcbs_store #(
  parameter int unsigned MAX_BOXES = 64,
  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [IdxW-1:0]              waddr_i,
  input  pcbs_pkg::box_t               wbox_i,
  input  logic [IdxW-1:0]              raddr_a_i,
  input  logic [IdxW-1:0]              raddr_b_i,
  output pcbs_pkg::box_t               rbox_a_o,
  output logic [pcbs_pkg::ScoreW-1:0]  rscore_b_o
);

  localparam int unsigned CW = 4 * pcbs_pkg::CoordW;
  localparam int unsigned SW = pcbs_pkg::ScoreW + pcbs_pkg::ClassW;

  logic [CW-1:0] coord_mem [MAX_BOXES];
  logic [SW-1:0] sc_mem    [MAX_BOXES];
  logic [CW-1:0] coord_a_q;
  logic [SW-1:0] sc_a_q;
  logic [SW-1:0] sc_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      coord_mem[waddr_i] <= {wbox_i.y2, wbox_i.x2, wbox_i.y1, wbox_i.x1};
      sc_mem[waddr_i]    <= {wbox_i.cls, wbox_i.score};
    end
    coord_a_q <= coord_mem[raddr_a_i];
    sc_a_q    <= sc_mem[raddr_a_i];
    sc_b_q    <= sc_mem[raddr_b_i];
  end

  assign rbox_a_o   = {sc_a_q, coord_a_q};
  assign rscore_b_o = sc_b_q[pcbs_pkg::ScoreW-1:0];

endmodule

[hw/rtl/pcbs_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pcbs_mul (
  input  logic               clk_i,
  input  logic signed [31:0] op_a_i,
  input  logic signed [16:0] op_b_i,
  output logic signed [48:0] prod_o
);

  logic signed [48:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/pcbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_ctrl
// sequencer: load, rank by score, pairwise suppression, result register
// ----------------------------------------------------------------------------
`include "per_class_box_suppression_assert.svh"

module pcbs_ctrl #(
  parameter int unsigned MAX_BOXES = 64,
  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pcbs_pkg::ThrW-1:0]     thr_i,
  // input stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pcbs_pkg::box_t                in_box_i,
  input  logic                          in_last_i,
  // result stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcbs_pkg::box_t                out_box_o,
  output logic                          out_last_o,
  output logic                          out_drop_o,
  // box store
  output logic                          st_we_o,
  output logic [IdxW-1:0]               st_waddr_o,
  output pcbs_pkg::box_t                st_wbox_o,
  output logic [IdxW-1:0]               st_raddr_a_o,
  output logic [IdxW-1:0]               st_raddr_b_o,
  input  pcbs_pkg::box_t                st_rbox_a_i,
  input  logic [pcbs_pkg::ScoreW-1:0]   st_rscore_b_i,
  // multiplier
  output logic signed [31:0]            mul_a_o,
  output logic signed [16:0]            mul_b_o,
  input  logic signed [48:0]            mul_prod_i
);

  pcbs_pkg::state_e state_q, state_d;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [IdxW-1:0]      i_q, i_d;
  logic [IdxW-1:0]      j_q, j_d;
  logic [IdxW-1:0]      rank_q, rank_d;
  logic [MAX_BOXES-1:0] supp_q, supp_d;
  logic                 pend_v_q, pend_v_d;
  logic                 out_v_q, out_v_d;

  pcbs_pkg::box_t       a_q, a_d;
  pcbs_pkg::box_t       b_q, b_d;
  pcbs_pkg::box_t       pend_q, pend_d;
  pcbs_pkg::box_t       out_box_q, out_box_d;
  logic                 out_last_q, out_last_d;
  logic                 out_drop_q, out_drop_d;
  logic signed [31:0]   area_a_q, area_a_d;
  logic signed [31:0]   inter_q, inter_d;
  logic signed [31:0]   uni_q, uni_d;

  logic [IdxW-1:0]      ord_mem [MAX_BOXES];
  logic [IdxW-1:0]      ord_rd_q;
  logic                 ord_we;
  logic [IdxW-1:0]      ord_waddr;
  logic [IdxW-1:0]      ord_raddr;

  logic in_acc;
  logic has_room;
  logic last_i;
  logic last_j;
  logic rank_inc;
  logic [IdxW-1:0] rank_next;
  logic out_free;
  logic same_cls;
  logic uni_nonpos;
  logic signed [48:0] lhs;
  logic hit;
  logic signed [pcbs_pkg::CoordW:0] ex_a, ey_a;
  logic signed [pcbs_pkg::CoordW:0] ex_k, ey_k;
  logic signed [pcbs_pkg::CoordW:0] ex_b, ey_b;
  logic [pcbs_pkg::CoordW-1:0] ov_w, ov_h;

  assign in_ready_o = (state_q == pcbs_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign has_room   = (cnt_q < CntW'(MAX_BOXES));
  assign last_i     = (CntW'(i_q) == cnt_q - 1'b1);
  assign last_j     = (CntW'(j_q) == cnt_q - 1'b1);
  assign out_free   = !out_v_q || out_ready_i;

  // ranking: a later box with equal score ranks behind
  assign rank_inc  = (st_rscore_b_i > st_rbox_a_i.score) ||
                     ((st_rscore_b_i == st_rbox_a_i.score) && (j_q < i_q));
  assign rank_next = rank_q + IdxW'(rank_inc);

  assign same_cls   = (st_rbox_a_i.cls == a_q.cls);
  assign uni_nonpos = uni_q[31] || (uni_q == '0);
  assign lhs        = {inter_q[31], inter_q, 16'b0};
  assign hit        = (lhs >= mul_prod_i);

  assign ex_a = pcbs_pkg::extent(st_rbox_a_i.x1, st_rbox_a_i.x2);
  assign ey_a = pcbs_pkg::extent(st_rbox_a_i.y1, st_rbox_a_i.y2);
  assign ex_k = pcbs_pkg::extent(a_q.x1, a_q.x2);
  assign ey_k = pcbs_pkg::extent(a_q.y1, a_q.y2);
  assign ex_b = pcbs_pkg::extent(b_q.x1, b_q.x2);
  assign ey_b = pcbs_pkg::extent(b_q.y1, b_q.y2);
  assign ov_w = pcbs_pkg::overlap(a_q.x1, a_q.x2, b_q.x1, b_q.x2);
  assign ov_h = pcbs_pkg::overlap(a_q.y1, a_q.y2, b_q.y1, b_q.y2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcbs_pkg::ST_LOAD: begin
        if (in_acc && in_last_i) state_d = pcbs_pkg::ST_RANK_RD;
      end
      pcbs_pkg::ST_RANK_RD:  state_d = pcbs_pkg::ST_RANK_CMP;
      pcbs_pkg::ST_RANK_CMP: begin
        if (last_j && last_i) state_d = pcbs_pkg::ST_SUP_I;
        else                  state_d = pcbs_pkg::ST_RANK_RD;
      end
      pcbs_pkg::ST_SUP_I: begin
        if (!supp_q[i_q])  state_d = pcbs_pkg::ST_SUP_A;
        else if (last_i)   state_d = pcbs_pkg::ST_FLUSH;
      end
      pcbs_pkg::ST_SUP_A:  state_d = pcbs_pkg::ST_SUP_AB;
      pcbs_pkg::ST_SUP_AB: state_d = pcbs_pkg::ST_SUP_AAREA;
      pcbs_pkg::ST_SUP_AAREA: begin
        if (!pend_v_q || out_free) begin
          if (last_i) state_d = pcbs_pkg::ST_FLUSH;
          else        state_d = pcbs_pkg::ST_PJ;
        end
      end
      pcbs_pkg::ST_PJ: begin
        if (!supp_q[j_q])  state_d = pcbs_pkg::ST_PB;
        else if (last_j)   state_d = last_i ? pcbs_pkg::ST_FLUSH : pcbs_pkg::ST_SUP_I;
      end
      pcbs_pkg::ST_PB: state_d = pcbs_pkg::ST_PC;
      pcbs_pkg::ST_PC: begin
        if (same_cls)    state_d = pcbs_pkg::ST_PI;
        else if (last_j) state_d = last_i ? pcbs_pkg::ST_FLUSH : pcbs_pkg::ST_SUP_I;
        else             state_d = pcbs_pkg::ST_PJ;
      end
      pcbs_pkg::ST_PI:    state_d = pcbs_pkg::ST_PAREA;
      pcbs_pkg::ST_PAREA: state_d = pcbs_pkg::ST_PU;
      pcbs_pkg::ST_PU:    state_d = pcbs_pkg::ST_PT;
      pcbs_pkg::ST_PT: begin
        if (!uni_nonpos) state_d = pcbs_pkg::ST_PCMP;
        else if (last_j) state_d = last_i ? pcbs_pkg::ST_FLUSH : pcbs_pkg::ST_SUP_I;
        else             state_d = pcbs_pkg::ST_PJ;
      end
      pcbs_pkg::ST_PCMP: begin
        if (last_j) state_d = last_i ? pcbs_pkg::ST_FLUSH : pcbs_pkg::ST_SUP_I;
        else        state_d = pcbs_pkg::ST_PJ;
      end
      pcbs_pkg::ST_FLUSH: begin
        if (out_free) state_d = pcbs_pkg::ST_LOAD;
      end
      default: state_d = pcbs_pkg::ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    rank_d     = rank_q;
    supp_d     = supp_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    a_d        = a_q;
    b_d        = b_q;
    area_a_d   = area_a_q;
    inter_d    = inter_q;
    uni_d      = uni_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_box_d  = out_box_q;
    out_last_d = out_last_q;
    out_drop_d = out_drop_q;
    st_we_o      = 1'b0;
    st_waddr_o   = cnt_q[IdxW-1:0];
    st_wbox_o    = in_box_i;
    st_raddr_a_o = i_q;
    st_raddr_b_o = j_q;
    ord_we       = 1'b0;
    ord_waddr    = rank_next;
    ord_raddr    = i_q;
    mul_a_o      = '0;
    mul_b_o      = '0;

    unique case (state_q)
      pcbs_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            st_we_o = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          i_d    = '0;
          j_d    = '0;
          rank_d = '0;
        end
      end
      pcbs_pkg::ST_RANK_RD: begin
        st_raddr_a_o = i_q;
        st_raddr_b_o = j_q;
      end
      pcbs_pkg::ST_RANK_CMP: begin
        if (last_j) begin
          ord_we = 1'b1;
          rank_d = '0;
          j_d    = '0;
          i_d    = last_i ? '0 : i_q + 1'b1;
        end else begin
          rank_d = rank_next;
          j_d    = j_q + 1'b1;
        end
      end
      pcbs_pkg::ST_SUP_I: begin
        ord_raddr = i_q;
        if (supp_q[i_q] && !last_i) i_d = i_q + 1'b1;
      end
      pcbs_pkg::ST_SUP_A: begin
        st_raddr_a_o = ord_rd_q;
      end
      pcbs_pkg::ST_SUP_AB: begin
        a_d     = st_rbox_a_i;
        mul_a_o = {{(31 - pcbs_pkg::CoordW){ex_a[pcbs_pkg::CoordW]}}, ex_a};
        mul_b_o = {{(16 - pcbs_pkg::CoordW){ey_a[pcbs_pkg::CoordW]}}, ey_a};
      end
      pcbs_pkg::ST_SUP_AAREA: begin
        area_a_d = mul_prod_i[31:0];
        // keep the area product alive while the output is stalled
        mul_a_o = {{(31 - pcbs_pkg::CoordW){ex_k[pcbs_pkg::CoordW]}}, ex_k};
        mul_b_o = {{(16 - pcbs_pkg::CoordW){ey_k[pcbs_pkg::CoordW]}}, ey_k};
        if (!pend_v_q || out_free) begin
          // the box just kept pushes the previous one out
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_box_d  = pend_q;
            out_last_d = 1'b0;
            out_drop_d = ovf_q;
          end
          pend_v_d = 1'b1;
          pend_d   = a_q;
          if (!last_i) j_d = i_q + 1'b1;
        end
      end
      pcbs_pkg::ST_PJ: begin
        ord_raddr = j_q;
        if (supp_q[j_q]) begin
          if (last_j) i_d = i_q + 1'b1;
          else        j_d = j_q + 1'b1;
        end
      end
      pcbs_pkg::ST_PB: begin
        st_raddr_a_o = ord_rd_q;
      end
      pcbs_pkg::ST_PC: begin
        b_d = st_rbox_a_i;
        if (!same_cls) begin
          if (last_j) i_d = i_q + 1'b1;
          else        j_d = j_q + 1'b1;
        end
      end
      pcbs_pkg::ST_PI: begin
        mul_a_o = {{(32 - pcbs_pkg::CoordW){1'b0}}, ov_w};
        mul_b_o = {{(17 - pcbs_pkg::CoordW){1'b0}}, ov_h};
      end
      pcbs_pkg::ST_PAREA: begin
        inter_d = mul_prod_i[31:0];
        mul_a_o = {{(31 - pcbs_pkg::CoordW){ex_b[pcbs_pkg::CoordW]}}, ex_b};
        mul_b_o = {{(16 - pcbs_pkg::CoordW){ey_b[pcbs_pkg::CoordW]}}, ey_b};
      end
      pcbs_pkg::ST_PU: begin
        uni_d = area_a_q + mul_prod_i[31:0] - inter_q;
      end
      pcbs_pkg::ST_PT: begin
        mul_a_o = uni_q;
        mul_b_o = {1'b0, thr_i};
        if (uni_nonpos) begin
          if (thr_i == '0) supp_d[j_q] = 1'b1;
          if (last_j) i_d = i_q + 1'b1;
          else        j_d = j_q + 1'b1;
        end
      end
      pcbs_pkg::ST_PCMP: begin
        if (hit) supp_d[j_q] = 1'b1;
        if (last_j) i_d = i_q + 1'b1;
        else        j_d = j_q + 1'b1;
      end
      pcbs_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_box_d  = pend_q;
          out_last_d = 1'b1;
          out_drop_d = ovf_q;
          pend_v_d   = 1'b0;
          cnt_d      = '0;
          ovf_d      = 1'b0;
          supp_d     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcbs_pkg::ST_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      supp_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rank_q   <= rank_d;
      supp_q   <= supp_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    pend_q     <= pend_d;
    out_box_q  <= out_box_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
    area_a_q   <= area_a_d;
    inter_q    <= inter_d;
    uni_q      <= uni_d;
  end

  // rank-to-slot table
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= i_q;
    ord_rd_q <= ord_mem[ord_raddr];
  end

  assign out_valid_o = out_v_q;
  assign out_box_o   = out_box_q;
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;

  `PCBS_ASSERT(a_cnt_max, cnt_q <= CntW'(MAX_BOXES), "box count above capacity")
  `PCBS_ASSERT(a_busy_cnt, state_q != pcbs_pkg::ST_LOAD |-> cnt_q != '0, "processing empty set")
  `PCBS_ASSERT(a_supp_clr, state_q == pcbs_pkg::ST_LOAD |-> supp_q == '0, "marks left over")
  `PCBS_ASSERT(a_pend_out, $fell(pend_v_q) |-> out_v_q && out_last_q, "pending box lost")

endmodule

[hw/rtl/per_class_box_suppression.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_suppression
// per-class greedy non-maximum suppression over one set of boxes
// ----------------------------------------------------------------------------
// Boxes arrive on the s_axis stream, one per transaction; tlast closes a set.
// Up to MAX_BOXES boxes are stored, further ones are dropped and every result
// of that set carries the dropped flag in m_axis_tuser. After the closing box
// the input stays not ready while the set is ranked and filtered: ranking
// compares scores through the store read ports, suppression tests pairs of
// one class through the store and one shared multiplier. Kept boxes leave on
// m_axis in descending score order, tlast on the final one; the first result
// appears after the ranking pass plus the first row of pair tests. A stalled
// m_axis holds the sequencer only when a further kept box is ready or the
// set ends; loading of the next set starts as soon as the final result sits
// in the output register. The threshold is to be written on the cfg channel
// only while idle, which the block does not enforce; it resets to 0.45.
// Reset empties the set and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_class_box_suppression #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pcbs_pkg::ThrW-1:0]    cfg_data_i,     // iou_threshold
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // box_x1, box_y1, box_x2, box_y2, box_score, box_class, zero pad
  input  logic [pcbs_pkg::DataW-1:0]   s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,  // set_last
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_x1, out_y1, out_x2, out_y2, out_score, out_class, zero pad
  output logic [pcbs_pkg::DataW-1:0]   m_axis_tdata_o,
  output logic                         m_axis_tlast_o,  // out_last
  output logic                         m_axis_tuser_o   // dropped_flag
);

  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic [pcbs_pkg::ThrW-1:0]   thr_q;
  pcbs_pkg::box_t              in_box;
  pcbs_pkg::box_t              out_box;
  logic                        st_we;
  logic [IdxW-1:0]             st_waddr;
  pcbs_pkg::box_t              st_wbox;
  logic [IdxW-1:0]             st_raddr_a;
  logic [IdxW-1:0]             st_raddr_b;
  pcbs_pkg::box_t              st_rbox_a;
  logic [pcbs_pkg::ScoreW-1:0] st_rscore_b;
  logic signed [31:0]          mul_a;
  logic signed [16:0]          mul_b;
  logic signed [48:0]          mul_prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pcbs_pkg::ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign in_box         = s_axis_tdata_i[pcbs_pkg::BoxW-1:0];
  assign m_axis_tdata_o = {{(pcbs_pkg::DataW - pcbs_pkg::BoxW){1'b0}}, out_box};

  pcbs_store #(.MAX_BOXES(MAX_BOXES)) u_store (
    .clk_i      (clk_i),
    .we_i       (st_we),
    .waddr_i    (st_waddr),
    .wbox_i     (st_wbox),
    .raddr_a_i  (st_raddr_a),
    .raddr_b_i  (st_raddr_b),
    .rbox_a_o   (st_rbox_a),
    .rscore_b_o (st_rscore_b)
  );

  pcbs_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (mul_prod)
  );

  pcbs_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .thr_i         (thr_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_box_i      (in_box),
    .in_last_i     (s_axis_tlast_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_box_o     (out_box),
    .out_last_o    (m_axis_tlast_o),
    .out_drop_o    (m_axis_tuser_o),
    .st_we_o       (st_we),
    .st_waddr_o    (st_waddr),
    .st_wbox_o     (st_wbox),
    .st_raddr_a_o  (st_raddr_a),
    .st_raddr_b_o  (st_raddr_b),
    .st_rbox_a_i   (st_rbox_a),
    .st_rscore_b_i (st_rscore_b),
    .mul_a_o       (mul_a),
    .mul_b_o       (mul_b),
    .mul_prod_i    (mul_prod)
  );

endmodule
